// ===== design/bbit_pkg.sv =====
// ----------------------------------------------------------------------------
// bbit_pkg: shared types and constants of the block biquad threshold core
// Field widths, register indexes, register reset values and the structs that
// carry coefficients and stage control between the modules.
// ----------------------------------------------------------------------------
package bbit_pkg;

  localparam int BLOCK_LEN_DEF  = 5;
  localparam int FRAC_BITS_DEF  = 14;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int Y_W      = 40;
  localparam int REG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL   = 3'd5;

  localparam logic signed [COEF_W-1:0] RST_COEF_B0 = 16'sd14133;
  localparam logic signed [COEF_W-1:0] RST_COEF_B1 = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_COEF_B2 = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_COEF_A1 = -16'sd2251;
  localparam logic signed [COEF_W-1:0] RST_COEF_A2 = 16'sd0;
  localparam logic signed [COEF_W-1:0] RST_LEVEL   = 16'sd50;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] level;
  } coef_t;

  // Control of the compute step for the item held in the input register.
  typedef struct packed {
    logic advance;  // item leaves the input register this cycle
    logic active;   // position two or later: recursion runs
    logic last;     // last item of a block
  } ctrl_t;

endpackage

// ===== design/bbit_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bbit_cfg_regs: configuration register file
// Holds the five filter coefficients and the compare level; writes to
// unused indexes are dropped.
// ----------------------------------------------------------------------------
module bbit_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bbit_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bbit_pkg::COEF_W-1:0]          cfg_wdata_i,
  output bbit_pkg::coef_t                      coef_o
);

  bbit_pkg::coef_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbit_pkg::REG_COEF_B0: coef_d.b0    = cfg_wdata_i;
        bbit_pkg::REG_COEF_B1: coef_d.b1    = cfg_wdata_i;
        bbit_pkg::REG_COEF_B2: coef_d.b2    = cfg_wdata_i;
        bbit_pkg::REG_COEF_A1: coef_d.a1    = cfg_wdata_i;
        bbit_pkg::REG_COEF_A2: coef_d.a2    = cfg_wdata_i;
        bbit_pkg::REG_LEVEL:   coef_d.level = cfg_wdata_i;
        default:               coef_d       = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0    <= bbit_pkg::RST_COEF_B0;
      coef_q.b1    <= bbit_pkg::RST_COEF_B1;
      coef_q.b2    <= bbit_pkg::RST_COEF_B2;
      coef_q.a1    <= bbit_pkg::RST_COEF_A1;
      coef_q.a2    <= bbit_pkg::RST_COEF_A2;
      coef_q.level <= bbit_pkg::RST_LEVEL;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== design/bbit_biquad.sv =====
// ----------------------------------------------------------------------------
// bbit_biquad: biquad recursion and its history registers
// Computes one output per item from the sample and the stored history, and
// shifts or clears the history as the item leaves the input register.
// ----------------------------------------------------------------------------
module bbit_biquad #(
  parameter int COEF_FRAC_BITS = bbit_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [bbit_pkg::SAMPLE_W-1:0] x_i,
  input  bbit_pkg::ctrl_t                      ctrl_i,
  input  bbit_pkg::coef_t                      coef_i,
  output logic signed [bbit_pkg::Y_W-1:0]      y_o
);

  localparam int SW     = bbit_pkg::SAMPLE_W;
  localparam int CW     = bbit_pkg::COEF_W;
  localparam int YW     = bbit_pkg::Y_W;
  localparam int FF_P_W = CW + SW;
  localparam int FF_W   = FF_P_W + 2;
  localparam int FB_P_W = CW + YW;
  localparam int FB_W   = FB_P_W + 1;
  localparam int ACC_W  = FB_W + 1;

  logic signed [SW-1:0] x1_q, x2_q;
  logic signed [YW-1:0] y1_q, y2_q;

  logic signed [FF_P_W-1:0] p_b0, p_b1, p_b2;
  logic signed [FB_P_W-1:0] p_a1, p_a2;
  logic signed [FF_W-1:0]   ff;
  logic signed [FB_W-1:0]   fb, fb_sh;
  logic signed [ACC_W-1:0]  acc;
  logic signed [YW-1:0]     y_sat;

  always_comb begin
    p_b0  = coef_i.b0 * x_i;
    p_b1  = coef_i.b1 * x1_q;
    p_b2  = coef_i.b2 * x2_q;
    p_a1  = coef_i.a1 * y1_q;
    p_a2  = coef_i.a2 * y2_q;
    ff    = FF_W'(p_b0) + FF_W'(p_b1) + FF_W'(p_b2);
    fb    = FB_W'(p_a1) + FB_W'(p_a2);
    // Arithmetic shift rounds the feedback toward minus infinity.
    fb_sh = fb >>> COEF_FRAC_BITS;
    acc   = ACC_W'(ff) - ACC_W'(fb_sh);
    // Clamp to the 40-bit range when the bits above it disagree with the sign.
    if (acc[ACC_W-1:YW-1] == {(ACC_W-YW+1){acc[ACC_W-1]}}) begin
      y_sat = acc[YW-1:0];
    end else if (acc[ACC_W-1]) begin
      y_sat = {1'b1, {(YW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(YW-1){1'b1}}};
    end
  end

  assign y_o = ctrl_i.active ? y_sat : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctrl_i.advance) begin
      if (ctrl_i.last) begin
        x1_q <= '0;
        x2_q <= '0;
        y1_q <= '0;
        y2_q <= '0;
      end else begin
        x1_q <= x_i;
        x2_q <= x1_q;
        y1_q <= y_o;
        y2_q <= y1_q;
      end
    end
  end

endmodule

// ===== design/bbit_result.sv =====
// ----------------------------------------------------------------------------
// bbit_result: result scaling, threshold flag and output register
// Drops the fraction toward zero, saturates to 16 bits, compares against the
// level and holds the result item until the sink takes it.
// ----------------------------------------------------------------------------
module bbit_result #(
  parameter int COEF_FRAC_BITS = bbit_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [bbit_pkg::Y_W-1:0]      y_i,
  input  bbit_pkg::ctrl_t                      ctrl_i,
  input  logic signed [bbit_pkg::COEF_W-1:0]   level_i,
  input  logic                                 ready_i,
  output logic                                 free_o,
  output logic                                 valid_o,
  output logic signed [bbit_pkg::SAMPLE_W-1:0] filtered_o,
  output logic                                 above_o
);

  localparam int YW = bbit_pkg::Y_W;
  localparam int OW = bbit_pkg::SAMPLE_W;
  localparam logic signed [YW-1:0] RND = YW'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  logic signed [YW-1:0] adj, r;
  logic signed [OW-1:0] filt;
  logic                 load;
  logic                 valid_q;
  logic signed [OW-1:0] filt_q;
  logic                 above_q;

  always_comb begin
    // Adding the fraction mask to negative values turns the floor shift into
    // truncation toward zero.
    adj = y_i + (y_i[YW-1] ? RND : '0);
    r   = adj >>> COEF_FRAC_BITS;
    if (r[YW-1:OW-1] == {(YW-OW+1){r[YW-1]}}) begin
      filt = r[OW-1:0];
    end else if (r[YW-1]) begin
      filt = {1'b1, {(OW-1){1'b0}}};
    end else begin
      filt = {1'b0, {(OW-1){1'b1}}};
    end
  end

  assign free_o = !valid_q || ready_i;
  assign load   = ctrl_i.advance && ctrl_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      filt_q  <= filt;
      above_q <= filt > level_i;
    end
  end

  assign valid_o    = valid_q;
  assign filtered_o = filt_q;
  assign above_o    = above_q;

endmodule

// ===== design/block_biquad_iir_threshold_core.sv =====
// ----------------------------------------------------------------------------
// block_biquad_iir_threshold_core: block biquad filter with threshold flag
// Throughput is one item per cycle while no closing sample is held back; the
// feedback loop runs through the history registers. A closing sample is held
// in the input register while an earlier result still waits for the sink.
// Reset restores the register defaults, clears the history and the block
// position, and leaves no result pending.
// ----------------------------------------------------------------------------
module block_biquad_iir_threshold_core #(
  parameter int BLOCK_LEN      = bbit_pkg::BLOCK_LEN_DEF,
  parameter int COEF_FRAC_BITS = bbit_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Sample stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [bbit_pkg::SAMPLE_W-1:0]        s_axis_tdata,   // [15:0] sample
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bbit_pkg::SAMPLE_W-1:0]        m_axis_tdata,   // [15:0] filtered
  output logic                                 m_axis_tuser,   // [0] above_level
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [bbit_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bbit_pkg::COEF_W-1:0]          cfg_wdata_i
);

  localparam int POS_W = $clog2(BLOCK_LEN);

  // The input register holds one accepted sample. It computes against the
  // history in the cycle it leaves, so the history always belongs to
  // earlier items of the same block.
  logic                                 in_valid_q;
  logic signed [bbit_pkg::SAMPLE_W-1:0] x_q;
  logic [POS_W-1:0]                     pos_q, pos_d;

  bbit_pkg::coef_t                      coef;
  bbit_pkg::ctrl_t                      ctrl;
  logic signed [bbit_pkg::Y_W-1:0]      y;
  logic                                 res_free;
  logic signed [bbit_pkg::SAMPLE_W-1:0] filtered;
  logic                                 is_last;
  logic                                 in_fire;

  bbit_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  // A sample that closes a block can only leave when the output register is
  // free to take its result; all other samples move on at once, so the input
  // side keeps flowing while a result waits, up to the next closing sample.
  assign is_last      = (pos_q == POS_W'(BLOCK_LEN - 1));
  assign ctrl.last    = is_last;
  assign ctrl.active  = (pos_q >= POS_W'(2));
  assign ctrl.advance = in_valid_q && (!is_last || res_free);

  assign s_axis_tready = !in_valid_q || ctrl.advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pos_d = pos_q;
    if (ctrl.advance) begin
      pos_d = is_last ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
    end else begin
      pos_q <= pos_d;
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (ctrl.advance) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= s_axis_tdata;
    end
  end

  bbit_biquad #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_biquad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (x_q),
    .ctrl_i (ctrl),
    .coef_i (coef),
    .y_o    (y)
  );

  bbit_result #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .y_i        (y),
    .ctrl_i     (ctrl),
    .level_i    (coef.level),
    .ready_i    (m_axis_tready),
    .free_o     (res_free),
    .valid_o    (m_axis_tvalid),
    .filtered_o (filtered),
    .above_o    (m_axis_tuser)
  );

  assign m_axis_tdata = filtered;

  // The block position never runs past the block length.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(BLOCK_LEN - 1))
    else $error("block position out of range");

  // A closing sample always produces a result on the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.advance && is_last |=> m_axis_tvalid)
    else $error("closing sample gave no result");

  // A waiting result is never overwritten by the next block.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !(ctrl.advance && is_last))
    else $error("pending result overwritten");

  // The input side only stalls while a closing sample waits for the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && is_last && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without cause");

endmodule
